FILE: hdl/pfr_pkg.sv
package pfr_pkg;

	// Link control characters
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_SYN = 8'h16;
	localparam logic [7:0] CH_CMD = 8'h23;

	localparam logic [8:0] FULL_LENGTH = 9'd256;

	localparam int SYNC_BLOCK_BYTES_DEF = 64;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_CMD,
		PH_CPL,
		PH_SEQ,
		PH_LEN,
		PH_OPT,
		PH_TYP,
		PH_DATA,
		PH_SUM
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_COMMAND  = 3'd1,
		EV_DATA     = 3'd2,
		EV_ACCEPTED = 3'd3,
		EV_SUM_FAIL = 3'd4,
		EV_SEQ_FAIL = 3'd5
	} event_t;

	typedef struct packed {
		logic       reply_valid;
		logic [7:0] reply_byte;
		logic [2:0] event_res;
		logic [7:0] command_code;
		logic [7:0] data_byte;
		logic [7:0] data_index;
		logic [8:0] packet_length;
		logic [7:0] packet_options;
		logic [7:0] packet_type_field;
		logic [7:0] sequence_number;
	} res_t;

endpackage

FILE: hdl/pfr_rx_if.sv
interface pfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/pfr_res_if.sv
interface pfr_res_if;
	logic       valid;
	logic       ready;
	logic       reply_valid;
	logic [7:0] reply_byte;
	logic [2:0] event_res;
	logic [7:0] command_code;
	logic [7:0] data_byte;
	logic [7:0] data_index;
	logic [8:0] packet_length;
	logic [7:0] packet_options;
	logic [7:0] packet_type_field;
	logic [7:0] sequence_number;

	modport source (
		output valid, input ready,
		output reply_valid, output reply_byte, output event_res, output command_code,
		output data_byte, output data_index, output packet_length, output packet_options,
		output packet_type_field, output sequence_number
	);
	modport sink (
		input valid, output ready,
		input reply_valid, input reply_byte, input event_res, input command_code,
		input data_byte, input data_index, input packet_length, input packet_options,
		input packet_type_field, input sequence_number
	);
endinterface

FILE: hdl/packet_frame_receiver_core.sv
// Receiver for a byte-serial frame link. Each item on rx is one received byte; each
// item on res is one reply and/or event (ACK, NAK or SYN to send back, plus command,
// data byte, packet accepted, checksum fail or sequence mismatch). Bytes that only
// advance the frame parser give no res item. The block takes one byte per clock
// cycle while no result stall holds it; a result passes through the input register
// and then the result register. The rate is set by the frame state machine, which
// updates all of its state once per byte.
// A full result register that is not being taken stalls only a byte that would
// produce another result. Data bytes are streamed out as they arrive; drop them
// when the packet ends with a checksum fail. A SYN is sent after every
// SYNC_BLOCK_BYTES payload bytes and after the last one (only once when both meet).
module packet_frame_receiver_core #(
	parameter int SYNC_BLOCK_BYTES = pfr_pkg::SYNC_BLOCK_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	pfr_rx_if.sink rx,
	pfr_res_if.source res
);

	// Block counter holds 0 .. BLOCK_BYTES-1; a block size below one acts as one
	localparam int BLOCK_BYTES = (SYNC_BLOCK_BYTES < 1) ? 1 : SYNC_BLOCK_BYTES;
	localparam int BLK_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
	localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCK_BYTES - 1);

	// Input register
	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	// Result register
	logic          valid_s2;
	pfr_pkg::res_t res_s2;

	// Frame state
	pfr_pkg::phase_t phase_q, phase_d;
	logic [7:0]       exp_seq_q, exp_seq_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [8:0]       len_q, len_d;
	logic [8:0]       rcv_q, rcv_d;
	logic [BLK_W-1:0] blk_q, blk_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       opt_q, opt_d;
	logic [7:0]       typ_q, typ_d;

	pfr_pkg::res_t res_d;
	logic          has_res;
	logic          advance;

	logic [8:0] rcv_inc;
	logic [7:0] sum_inc;

	assign rcv_inc = rcv_q + 9'd1;
	assign sum_inc = sum_q + rx_byte_s1;

	// Advance the byte in stage 1 when its result has a free slot, or it has no result
	assign has_res = res_d.reply_valid || (res_d.event_res != pfr_pkg::EV_NONE);
	assign advance = valid_s1 && (!valid_s2 || res.ready || !has_res);
	assign rx.ready = !valid_s1 || advance;

	// Next state of the frame parser
	always_comb begin
		phase_d   = phase_q;
		exp_seq_d = exp_seq_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		rcv_d     = rcv_q;
		blk_d     = blk_q;
		sum_d     = sum_q;
		opt_d     = opt_q;
		typ_d     = typ_q;
		case (phase_q)
			pfr_pkg::PH_IDLE: begin
				if (rx_byte_s1 == pfr_pkg::CH_CMD) begin
					phase_d = pfr_pkg::PH_CMD;
				end else if (rx_byte_s1 == pfr_pkg::CH_SOH) begin
					phase_d = pfr_pkg::PH_SEQ;
				end
			end
			pfr_pkg::PH_CMD: begin
				cmd_d   = rx_byte_s1;
				phase_d = pfr_pkg::PH_CPL;
			end
			pfr_pkg::PH_CPL: begin
				phase_d = pfr_pkg::PH_IDLE;
			end
			pfr_pkg::PH_SEQ: begin
				phase_d = (rx_byte_s1 == exp_seq_q) ? pfr_pkg::PH_LEN : pfr_pkg::PH_IDLE;
			end
			pfr_pkg::PH_LEN: begin
				len_d   = (rx_byte_s1 == 8'd0) ? pfr_pkg::FULL_LENGTH : {1'b0, rx_byte_s1};
				sum_d   = rx_byte_s1;
				phase_d = pfr_pkg::PH_OPT;
			end
			pfr_pkg::PH_OPT: begin
				opt_d   = rx_byte_s1;
				sum_d   = sum_inc;
				phase_d = pfr_pkg::PH_TYP;
			end
			pfr_pkg::PH_TYP: begin
				typ_d   = rx_byte_s1;
				sum_d   = sum_inc;
				rcv_d   = '0;
				blk_d   = '0;
				phase_d = pfr_pkg::PH_DATA;
			end
			pfr_pkg::PH_DATA: begin
				sum_d = sum_inc;
				rcv_d = rcv_inc;
				blk_d = (blk_q == BLK_LAST) ? '0 : blk_q + BLK_W'(1);
				if (rcv_inc >= len_q) begin
					phase_d = pfr_pkg::PH_SUM;
				end
			end
			pfr_pkg::PH_SUM: begin
				if (rx_byte_s1 == sum_q) begin
					exp_seq_d = exp_seq_q + 8'd1;
				end
				phase_d = pfr_pkg::PH_IDLE;
			end
			default: begin
				phase_d = pfr_pkg::PH_IDLE;
			end
		endcase
	end

	// Result for the byte in stage 1; unused fields stay zero
	always_comb begin
		res_d = '0;
		case (phase_q)
			pfr_pkg::PH_CPL: begin
				if (cmd_q == ~rx_byte_s1) begin
					res_d.reply_valid  = 1'b1;
					res_d.reply_byte   = pfr_pkg::CH_ACK;
					res_d.event_res    = pfr_pkg::EV_COMMAND;
					res_d.command_code = cmd_q;
				end
			end
			pfr_pkg::PH_SEQ: begin
				res_d.reply_valid = 1'b1;
				if (rx_byte_s1 == exp_seq_q) begin
					res_d.reply_byte = pfr_pkg::CH_SYN;
				end else begin
					res_d.reply_byte      = pfr_pkg::CH_NAK;
					res_d.event_res       = pfr_pkg::EV_SEQ_FAIL;
					res_d.sequence_number = exp_seq_q;
				end
			end
			pfr_pkg::PH_TYP: begin
				res_d.reply_valid = 1'b1;
				res_d.reply_byte  = pfr_pkg::CH_SYN;
			end
			pfr_pkg::PH_DATA: begin
				res_d.event_res         = pfr_pkg::EV_DATA;
				res_d.data_byte         = rx_byte_s1;
				res_d.data_index        = rcv_q[7:0];
				res_d.packet_length     = len_q;
				res_d.packet_options    = opt_q;
				res_d.packet_type_field = typ_q;
				res_d.sequence_number   = exp_seq_q;
				// SYN at end of payload or at a block boundary
				if ((rcv_inc >= len_q) || (blk_q == BLK_LAST)) begin
					res_d.reply_valid = 1'b1;
					res_d.reply_byte  = pfr_pkg::CH_SYN;
				end
			end
			pfr_pkg::PH_SUM: begin
				res_d.reply_valid       = 1'b1;
				res_d.packet_length     = len_q;
				res_d.packet_options    = opt_q;
				res_d.packet_type_field = typ_q;
				res_d.sequence_number   = exp_seq_q;
				if (rx_byte_s1 == sum_q) begin
					res_d.reply_byte = pfr_pkg::CH_ACK;
					res_d.event_res  = pfr_pkg::EV_ACCEPTED;
				end else begin
					res_d.reply_byte = pfr_pkg::CH_NAK;
					res_d.event_res  = pfr_pkg::EV_SUM_FAIL;
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	// Input register: hold until the byte advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	// Frame state: update once per advanced byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= pfr_pkg::PH_IDLE;
			exp_seq_q <= '0;
			cmd_q     <= '0;
			len_q     <= '0;
			rcv_q     <= '0;
			blk_q     <= '0;
			sum_q     <= '0;
			opt_q     <= '0;
			typ_q     <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			exp_seq_q <= exp_seq_d;
			cmd_q     <= cmd_d;
			len_q     <= len_d;
			rcv_q     <= rcv_d;
			blk_q     <= blk_d;
			sum_q     <= sum_d;
			opt_q     <= opt_d;
			typ_q     <= typ_d;
		end
	end

	// Result register: load on an advancing byte with a result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && has_res) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_s2 <= res_d;
		end
	end

	assign res.valid             = valid_s2;
	assign res.reply_valid       = res_s2.reply_valid;
	assign res.reply_byte        = res_s2.reply_byte;
	assign res.event_res         = res_s2.event_res;
	assign res.command_code      = res_s2.command_code;
	assign res.data_byte         = res_s2.data_byte;
	assign res.data_index        = res_s2.data_index;
	assign res.packet_length     = res_s2.packet_length;
	assign res.packet_options    = res_s2.packet_options;
	assign res.packet_type_field = res_s2.packet_type_field;
	assign res.sequence_number   = res_s2.sequence_number;

endmodule

FILE: dv/pfr_frame_checker.sv
module pfr_frame_checker #(
	parameter int SYNC_BLOCK_BYTES = pfr_pkg::SYNC_BLOCK_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	pfr_rx_if   rx,
	pfr_res_if  res,
	output int  mismatches,
	output int  pending
);

	localparam int BLOCK = (SYNC_BLOCK_BYTES < 1) ? 1 : SYNC_BLOCK_BYTES;

	// Mirror of the frame parser state
	pfr_pkg::phase_t frame_phase;
	logic [7:0] rx_seq;
	logic [7:0] cmd_hold;
	logic [8:0] pay_len;
	logic [8:0] pay_count;
	logic [7:0] sum_acc;
	logic [7:0] opt_hold;
	logic [7:0] typ_hold;

	pfr_pkg::res_t replies_due[$];
	int   fails = 0;
	int   result_no = 0;

	// Advance the parser by one byte; return 1 when the byte yields a result item.
	function automatic bit frame_step(input logic [7:0] b, output pfr_pkg::res_t r);
		bit emits;
		r = '0;
		emits = 1'b0;
		case (frame_phase)
			pfr_pkg::PH_IDLE: begin
				if (b == pfr_pkg::CH_CMD)
					frame_phase = pfr_pkg::PH_CMD;
				else if (b == pfr_pkg::CH_SOH)
					frame_phase = pfr_pkg::PH_SEQ;
			end
			pfr_pkg::PH_CMD: begin
				cmd_hold = b;
				frame_phase = pfr_pkg::PH_CPL;
			end
			pfr_pkg::PH_CPL: begin
				if (cmd_hold == ~b) begin
					emits = 1'b1;
					r.reply_valid = 1'b1;
					r.reply_byte = pfr_pkg::CH_ACK;
					r.event_res = pfr_pkg::EV_COMMAND;
					r.command_code = cmd_hold;
				end
				frame_phase = pfr_pkg::PH_IDLE;
			end
			pfr_pkg::PH_SEQ: begin
				emits = 1'b1;
				r.reply_valid = 1'b1;
				if (b == rx_seq) begin
					r.reply_byte = pfr_pkg::CH_SYN;
					frame_phase = pfr_pkg::PH_LEN;
				end else begin
					r.reply_byte = pfr_pkg::CH_NAK;
					r.event_res = pfr_pkg::EV_SEQ_FAIL;
					r.sequence_number = rx_seq;
					frame_phase = pfr_pkg::PH_IDLE;
				end
			end
			pfr_pkg::PH_LEN: begin
				pay_len = (b == 8'd0) ? pfr_pkg::FULL_LENGTH : {1'b0, b};
				sum_acc = b;
				frame_phase = pfr_pkg::PH_OPT;
			end
			pfr_pkg::PH_OPT: begin
				opt_hold = b;
				sum_acc = sum_acc + b;
				frame_phase = pfr_pkg::PH_TYP;
			end
			pfr_pkg::PH_TYP: begin
				typ_hold = b;
				sum_acc = sum_acc + b;
				pay_count = '0;
				emits = 1'b1;
				r.reply_valid = 1'b1;
				r.reply_byte = pfr_pkg::CH_SYN;
				frame_phase = pfr_pkg::PH_DATA;
			end
			pfr_pkg::PH_DATA: begin
				emits = 1'b1;
				r.event_res = pfr_pkg::EV_DATA;
				r.data_byte = b;
				r.data_index = pay_count[7:0];
				r.packet_length = pay_len;
				r.packet_options = opt_hold;
				r.packet_type_field = typ_hold;
				r.sequence_number = rx_seq;
				sum_acc = sum_acc + b;
				pay_count = pay_count + 9'd1;
				if (pay_count >= pay_len) begin
					r.reply_valid = 1'b1;
					r.reply_byte = pfr_pkg::CH_SYN;
					frame_phase = pfr_pkg::PH_SUM;
				end else if ((pay_count % BLOCK) == 0) begin
					r.reply_valid = 1'b1;
					r.reply_byte = pfr_pkg::CH_SYN;
				end
			end
			pfr_pkg::PH_SUM: begin
				emits = 1'b1;
				r.reply_valid = 1'b1;
				r.packet_length = pay_len;
				r.packet_options = opt_hold;
				r.packet_type_field = typ_hold;
				r.sequence_number = rx_seq;
				if (b == sum_acc) begin
					r.reply_byte = pfr_pkg::CH_ACK;
					r.event_res = pfr_pkg::EV_ACCEPTED;
					rx_seq = rx_seq + 8'd1;
				end else begin
					r.reply_byte = pfr_pkg::CH_NAK;
					r.event_res = pfr_pkg::EV_SUM_FAIL;
				end
				frame_phase = pfr_pkg::PH_IDLE;
			end
			default: frame_phase = pfr_pkg::PH_IDLE;
		endcase
		return emits;
	endfunction

	task automatic check_field(input string fname, input logic [8:0] want, input logic [8:0] seen);
		if (want !== seen) begin
			if (fails < 10)
				$display("result %0d: %s expected 0x%0h, got 0x%0h", result_no, fname, want, seen);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		pfr_pkg::res_t due;
		if (!arst_n) begin
			frame_phase = pfr_pkg::PH_IDLE;
			rx_seq = '0;
			cmd_hold = '0;
			pay_len = '0;
			pay_count = '0;
			sum_acc = '0;
			opt_hold = '0;
			typ_hold = '0;
			replies_due.delete();
		end else begin
			// A byte taken at this edge cannot produce a result at the same edge.
			if (rx.valid && rx.ready) begin
				if (frame_step(rx.rx_byte, due))
					replies_due.push_back(due);
			end
			if (res.valid && res.ready) begin
				if (replies_due.size() == 0) begin
					if (fails < 10)
						$display("result %0d: unexpected, reply 0x%0h event %0d", result_no,
							res.reply_byte, res.event_res);
					fails++;
				end else begin
					due = replies_due.pop_front();
					check_field("reply_valid", 9'(due.reply_valid), 9'(res.reply_valid));
					check_field("reply_byte", 9'(due.reply_byte), 9'(res.reply_byte));
					check_field("event_res", 9'(due.event_res), 9'(res.event_res));
					check_field("command_code", 9'(due.command_code), 9'(res.command_code));
					check_field("data_byte", 9'(due.data_byte), 9'(res.data_byte));
					check_field("data_index", 9'(due.data_index), 9'(res.data_index));
					check_field("packet_length", due.packet_length, res.packet_length);
					check_field("packet_options", 9'(due.packet_options),
						9'(res.packet_options));
					check_field("packet_type_field", 9'(due.packet_type_field),
						9'(res.packet_type_field));
					check_field("sequence_number", 9'(due.sequence_number),
						9'(res.sequence_number));
				end
				result_no++;
			end
		end
		mismatches <= fails;
		pending <= replies_due.size();
	end

endmodule

FILE: dv/tb_packet_frame_receiver_core.sv
module tb_packet_frame_receiver_core;

	localparam int BLOCK_BYTES = pfr_pkg::SYNC_BLOCK_BYTES_DEF;
	// Frame bytes in the random mix, noise not counted
	localparam int MIX_BYTES = 1750;
	// Cycles to let pass after the last expected result
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;

	pfr_rx_if  rx ();
	pfr_res_if res ();

	int mismatches;
	int pending;

	// Sequence number the block should expect next, tracked on the sending side
	logic [7:0]  tx_seq;
	int unsigned bytes_sent;
	int unsigned noise_sent;
	int unsigned mix_start;
	// Gap-free stretches on either side
	bit          steady_rx;
	bit          steady_res;
	int unsigned res_hold;

	packet_frame_receiver_core #(
		.SYNC_BLOCK_BYTES(BLOCK_BYTES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx),
		.res   (res)
	);

	pfr_frame_checker #(
		.SYNC_BLOCK_BYTES(BLOCK_BYTES)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.res       (res),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the handshakes hang.
	initial begin
		#1600000;
		$display("Verification failed");
		$finish;
	end

	// Result side: after each taken item, hold ready low while a randomly drawn res_hold counts down,
	// except during steady stretches where ready stays high.
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			res_hold = 0;
		end else begin
			if (res.valid && res.ready) begin
				if ($urandom_range(0, 31) == 0)
					steady_res = !steady_res;
				res_hold = steady_res ? 0 : $urandom_range(0, 3);
			end
			if (res_hold != 0) begin
				res.ready <= 1'b0;
				res_hold--;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Offer one byte after a random gap and return at the edge where it is taken.
	// Valid gets a single assignment per edge: either dropped for the gap or
	// raised with the new byte.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = steady_rx ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		bytes_sent++;
	endtask

	// Command frame: '#', code, complement. Garble the complement to test the drop.
	task automatic send_command(input logic [7:0] cmd, input bit garbled);
		logic [7:0] cpl;
		cpl = ~cmd;
		if (garbled)
			cpl = cpl ^ 8'($urandom_range(1, 255));
		send_byte(pfr_pkg::CH_CMD);
		send_byte(cmd);
		send_byte(cpl);
	endtask

	// Packet frame with random options, type and payload. A wrong sequence byte
	// ends the frame right there; a wrong checksum flips one bit of the sum.
	task automatic send_packet(input logic [7:0] len_code, input bit wrong_seq,
		input bit wrong_sum);
		logic [7:0] opt;
		logic [7:0] typ;
		logic [7:0] d;
		logic [7:0] sum;
		int         n;
		send_byte(pfr_pkg::CH_SOH);
		if (wrong_seq) begin
			send_byte(tx_seq + 8'($urandom_range(1, 255)));
			return;
		end
		send_byte(tx_seq);
		opt = 8'($urandom);
		typ = 8'($urandom);
		sum = len_code + opt + typ;
		send_byte(len_code);
		send_byte(opt);
		send_byte(typ);
		n = (len_code == 8'd0) ? 256 : int'(len_code);
		repeat (n) begin
			d = 8'($urandom);
			sum = sum + d;
			send_byte(d);
		end
		if (wrong_sum)
			sum = sum ^ (8'h01 << $urandom_range(0, 7));
		send_byte(sum);
		if (!wrong_sum)
			tx_seq = tx_seq + 8'd1;
	endtask

	// Drop valid and hold until every expected result has been taken. Wait for
	// an edge before the first sample so the count includes the byte taken at this edge.
	task automatic drain_results();
		rx.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Mostly short payloads; a few hit the block boundaries and the full length.
	function automatic logic [7:0] pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 8'($urandom_range(1, 8));
		else if (r < 85)
			return 8'($urandom_range(9, 40));
		else if (r < 92) begin
			case ($urandom_range(0, 4))
				0: return 8'd63;
				1: return 8'd64;
				2: return 8'd65;
				3: return 8'd127;
				default: return 8'd128;
			endcase
		end else if (r < 97)
			return 8'($urandom_range(41, 255));
		else
			return 8'd0;
	endfunction

	initial begin
		int unsigned pick;
		logic [7:0]  b;

		// Drive every input to a known value before the first edge.
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = 8'h00;
		res.ready = 1'b0;
		tx_seq = 8'd0;
		bytes_sent = 0;
		noise_sent = 0;
		steady_rx = 1'b0;
		steady_res = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Stray bytes in idle: ignore, no result.
		send_byte(8'h00);
		send_byte(8'hFF);
		// Commands at both code extremes, then one with a bad complement.
		send_command(8'h00, 1'b0);
		send_command(8'hFF, 1'b0);
		send_command(8'h5A, 1'b1);
		// Sequence mismatch: block expects 0 here.
		send_byte(pfr_pkg::CH_SOH);
		send_byte(8'h07);
		// Good one-byte packet, checksum 0x01 + 0xFF + 0x00 + 0xFF = 0xFF.
		send_byte(pfr_pkg::CH_SOH);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		// Bad checksum on the next sequence number, correct sum would be 0x00.
		send_byte(pfr_pkg::CH_SOH);
		send_byte(8'h01);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h01);
		tx_seq = 8'd1;

		// Pause the sender until all results are in.
		drain_results();

		// Random mix of frames, errors, noise and sender pauses.
		mix_start = bytes_sent - noise_sent;
		while (bytes_sent - noise_sent - mix_start < MIX_BYTES) begin
			steady_rx = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// Noise must not open a frame, or the sender loses track.
				do
					b = 8'($urandom);
				while (b == pfr_pkg::CH_CMD || b == pfr_pkg::CH_SOH);
				send_byte(b);
				noise_sent++;
			end else if (pick < 20) begin
				send_command(8'($urandom), ($urandom_range(0, 6) == 0));
			end else if (pick < 23) begin
				drain_results();
			end else begin
				send_packet(pick_length(), ($urandom_range(0, 99) < 8),
					($urandom_range(0, 99) < 15));
			end
		end

		// Wait for the last results, then let the block settle while idle.
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
